### src/bmp8_pkg.sv
`timescale 1ns / 1ps

package bmp8_pkg;

	// image limits
	localparam int unsigned MAX_WIDTH  = 2048;
	localparam int unsigned MAX_HEIGHT = 2048;

	// counter widths follow from the limits
	localparam int unsigned COL_W = $clog2(MAX_WIDTH + 4);
	localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 1);

	// header layout
	localparam int unsigned IDX_W      = 11;
	localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(14 + 40 + 1024 - 1);

	// signature bytes
	localparam logic [7:0] SIG_B = 8'h42;
	localparam logic [7:0] SIG_M = 8'h4D;

	// result kinds
	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// error codes
	localparam logic [1:0] ERR_SIG  = 2'd0;
	localparam logic [1:0] ERR_INFO = 2'd1;
	localparam logic [1:0] ERR_SIZE = 2'd2;

	localparam int unsigned TDATA_W = 88;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PIXELS,
		PH_IDLE
	} phase_t;

	typedef struct packed {
		logic sig_bad;
		logic fix_bad;
	} chk_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  pixel;
		logic [10:0] row;
		logic [10:0] col;
		logic        last;
		logic [1:0]  err;
		logic [31:0] size_field;
		logic [11:0] width;
		logic [11:0] height;
	} res_t;

endpackage

### src/bmp8_hdr_chk.sv
`timescale 1ns / 1ps

module bmp8_hdr_chk import bmp8_pkg::*; (
	input  logic [IDX_W-1:0] idx,
	input  logic [7:0]       data,
	output chk_t             chk
);

	logic       fixed;
	logic [7:0] need;

	// fixed info-header bytes: size 40, one plane, 8 bpp, zero colors used
	always_comb begin
		fixed = 1'b1;
		need  = 8'd0;
		case (idx)
			11'd14: need = 8'd40;
			11'd15, 11'd16, 11'd17: need = 8'd0;
			11'd26: need = 8'd1;
			11'd27: need = 8'd0;
			11'd28: need = 8'd8;
			11'd29: need = 8'd0;
			11'd46, 11'd47, 11'd48, 11'd49: need = 8'd0;
			default: fixed = 1'b0;
		endcase
	end

	always_comb begin
		chk.sig_bad = ((idx == 11'd0) && (data != SIG_B)) ||
			((idx == 11'd1) && (data != SIG_M));
		chk.fix_bad = fixed && (data != need);
	end

endmodule

### src/bmp8_stream_parser_core.sv
`timescale 1ns / 1ps

// Byte-serial parser for 8-bit palette-indexed bitmap files. One file byte
// is taken per beat on the slave side; s_tuser high marks the first byte
// of a new file and clears all parser state (after reset the first byte is
// byte 0 anyway). The 14-byte file header must start with "BM"; the 40-byte
// info header must give header size 40, one plane, 8 bpp and zero
// colors used, otherwise an error beat goes out on the offending byte. The
// 1024 palette bytes are skipped, and on the last one a header beat reports
// file size, width and height, or an error beat if width or height exceeds
// the limit. Then every pixel byte goes out with its row (file order) and
// column, row padding is dropped, and tlast marks the final pixel. After an
// error or the end of the image, bytes are swallowed until the next start.
// Throughput is one byte per clock while the skid register is empty: all
// header checks and counter updates happen in the cycle the byte is accepted,
// and the result is registered in the two-entry output buffer (main register
// plus skid register), which keeps the slave side open while one result waits.
module bmp8_stream_parser_core import bmp8_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // data_byte[7:0]
	input  logic [0:0]         s_tuser,   // start_req[0]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // pixel[7:0], row[18:8], col[29:19],
	                                      // error_code[31:30], size_field[63:32],
	                                      // width[75:64], height[87:76]
	output logic [1:0]         m_tuser,   // kind[1:0]
	output logic               m_tlast    // last
);

	// parser state
	phase_t             phase_q, phase_n;
	logic [IDX_W-1:0]   idx_q, idx_n;
	logic [31:0]        size_q, size_n;
	logic [31:0]        width_q, width_n;
	logic [31:0]        height_q, height_n;
	logic [COL_W-1:0]   col_q, col_n;
	logic [ROW_W-1:0]   row_q, row_n;

	// state as seen by this byte (start request clears it first)
	logic               start;
	phase_t             ph_e;
	logic [IDX_W-1:0]   idx_e;
	logic [31:0]        size_e, width_e, height_e;
	logic [COL_W-1:0]   col_e;
	logic [ROW_W-1:0]   row_e;

	chk_t               chk;
	res_t               res;
	logic               res_v;
	logic               err_hit;
	logic               hdr_done;
	logic               img_done;

	// pixel phase helpers
	logic [COL_W-1:0]   wc;
	logic [ROW_W-1:0]   hc;
	logic [1:0]         pad;
	logic [COL_W:0]     row_len;
	logic [COL_W:0]     col_nx;
	logic [ROW_W:0]     row_nx;
	logic [4:0]         sh;

	// output buffer
	res_t               out_q, skid_q;
	logic               out_valid_q, skid_valid_q;
	logic               accept, push;

	assign start    = s_tuser[0];
	assign ph_e     = start ? PH_HEADER : phase_q;
	assign idx_e    = start ? '0 : idx_q;
	assign size_e   = start ? '0 : size_q;
	assign width_e  = start ? '0 : width_q;
	assign height_e = start ? '0 : height_q;
	assign col_e    = start ? '0 : col_q;
	assign row_e    = start ? '0 : row_q;

	assign accept = s_tvalid && s_tready;
	assign push   = accept && res_v;

	bmp8_hdr_chk u_chk (
		.idx  (idx_e),
		.data (s_tdata),
		.chk  (chk)
	);

	// the three little-endian fields all start at an offset that is 2 mod 4
	assign sh = {2'(idx_e[1:0] - 2'd2), 3'b000};

	// in the pixel phase width and height already passed the limit check
	assign wc      = width_e[COL_W-1:0];
	assign hc      = height_e[ROW_W-1:0];
	assign pad     = 2'(2'd0 - wc[1:0]);
	assign row_len = {1'b0, wc} + {{(COL_W-1){1'b0}}, pad};
	assign col_nx  = {1'b0, col_e} + 1'b1;
	assign row_nx  = {1'b0, row_e} + 1'b1;

	// datapath: result and counter updates for the current byte
	always_comb begin
		res      = '0;
		res_v    = 1'b0;
		err_hit  = 1'b0;
		hdr_done = 1'b0;
		img_done = 1'b0;
		idx_n    = idx_e;
		size_n   = size_e;
		width_n  = width_e;
		height_n = height_e;
		col_n    = col_e;
		row_n    = row_e;
		case (ph_e)
			PH_HEADER: begin
				if (chk.sig_bad) begin
					res.kind = KIND_ERROR;
					res.err  = ERR_SIG;
					res_v    = 1'b1;
					err_hit  = 1'b1;
				end else if (chk.fix_bad) begin
					res.kind = KIND_ERROR;
					res.err  = ERR_INFO;
					res_v    = 1'b1;
					err_hit  = 1'b1;
				end else begin
					// gather file size, width and height
					if (idx_e >= 11'd2 && idx_e <= 11'd5)
						size_n = size_e | ({24'd0, s_tdata} << sh);
					else if (idx_e >= 11'd18 && idx_e <= 11'd21)
						width_n = width_e | ({24'd0, s_tdata} << sh);
					else if (idx_e >= 11'd22 && idx_e <= 11'd25)
						height_n = height_e | ({24'd0, s_tdata} << sh);

					if (idx_e < HDR_LAST) begin
						idx_n = idx_e + 1'b1;
					end else if (width_n > 32'(MAX_WIDTH) ||
						height_n > 32'(MAX_HEIGHT)) begin
						res.kind = KIND_ERROR;
						res.err  = ERR_SIZE;
						res_v    = 1'b1;
						err_hit  = 1'b1;
					end else begin
						res.kind       = KIND_HEADER;
						res.size_field = size_n;
						res.width      = width_n[11:0];
						res.height     = height_n[11:0];
						res_v          = 1'b1;
						hdr_done       = 1'b1;
						col_n          = '0;
						row_n          = '0;
					end
				end
			end
			PH_PIXELS: begin
				if (col_e < wc) begin
					res.kind  = KIND_PIXEL;
					res.pixel = s_tdata;
					res.row   = 11'(row_e);
					res.col   = 11'(col_e);
					res.last  = (row_nx == {1'b0, hc}) && (col_nx == {1'b0, wc});
					res_v     = 1'b1;
				end
				// padding bytes produce no result; they only advance the column and row counters
				if (col_nx >= row_len) begin
					col_n = '0;
					row_n = row_nx[ROW_W-1:0];
					if (row_nx >= {1'b0, hc})
						img_done = 1'b1;
				end else begin
					col_n = col_nx[COL_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// next phase
	always_comb begin
		phase_n = ph_e;
		case (ph_e)
			PH_HEADER: begin
				if (err_hit)
					phase_n = PH_IDLE;
				else if (hdr_done)
					phase_n = (width_n == 32'd0 || height_n == 32'd0) ? PH_IDLE : PH_PIXELS;
			end
			PH_PIXELS: begin
				if (img_done)
					phase_n = PH_IDLE;
			end
			default: phase_n = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			idx_q    <= '0;
			size_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_n;
			idx_q    <= idx_n;
			size_q   <= size_n;
			width_q  <= width_n;
			height_q <= height_n;
			col_q    <= col_n;
			row_q    <= row_n;
		end
	end

	// output buffer: skid only fills while the main register is stalled,
	// and the slave side closes while the skid holds a beat
	assign s_tready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (push)
				out_q <= res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {out_q.height, out_q.width, out_q.size_field, out_q.err,
		out_q.col, out_q.row, out_q.pixel};

	// skid never holds a beat unless the main register does
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while output register empty");

	// an error always sends the parser idle
	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(push && res.kind == KIND_ERROR) |=> (phase_q == PH_IDLE))
		else $error("parser not idle after error");

	// with no row padding the final pixel ends the image
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(push && res.kind == KIND_PIXEL && res.last && pad == 2'd0)
		|=> (phase_q == PH_IDLE))
		else $error("parser not idle after final pixel");

	// only pixel beats may carry tlast
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser == KIND_PIXEL))
		else $error("tlast on a non-pixel beat");

endmodule
